FILE: design/mscc_pkg.sv
`default_nettype none
package mscc_pkg;

  localparam int GRID_POINTS = 64;
  localparam int DIV_BITS    = 15;
  localparam int DEN_W       = 16;
  localparam int PROD_W      = DIV_BITS + DEN_W;
  localparam int MUL_W       = 21;
  localparam int PT_W        = 23;
  localparam int FIFO_DEPTH  = 32;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] CFG_STEP_X    = 3'd3;
  localparam logic [2:0] CFG_STEP_Y    = 3'd4;

  localparam logic [1:0] EDGE_L = 2'd0;
  localparam logic [1:0] EDGE_B = 2'd1;
  localparam logic [1:0] EDGE_T = 2'd2;
  localparam logic [1:0] EDGE_R = 2'd3;

  localparam logic [3:0] CODE_NONE_LO = 4'd0;
  localparam logic [3:0] CODE_NONE_HI = 4'd15;
  localparam logic [3:0] CODE_SADDLE_A = 4'd5;
  localparam logic [3:0] CODE_SADDLE_B = 4'd10;

  typedef struct packed {
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic signed [15:0] corner_bl;
    logic signed [15:0] corner_br;
    logic signed [15:0] corner_tr;
    logic signed [15:0] corner_tl;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [3:0]  case_code;
    logic        last_segment;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] threshold;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [14:0] step_x;
    logic [14:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      code;
    logic [PT_W-1:0] ox;
    logic [PT_W-1:0] oy;
  } meta_t;

  typedef struct packed {
    logic                        valid;
    logic [3:0][PROD_W-1:0]      prod;
    logic [3:0][DEN_W-1:0]       den;
    meta_t                       meta;
  } front_t;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } seg_t;

  typedef struct packed {
    seg_t       seg0;
    seg_t       seg1;
    logic [3:0] code;
    logic       two;
  } ent_t;

  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
    logic signed [16:0] d;
    logic [16:0] m;
    d = 17'(a) - 17'(b);
    m = d[16] ? 17'(-d) : 17'(d);
    return m[15:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [PT_W-1:0] v);
    logic signed [PT_W-1:0] s;
    s = signed'(v);
    if (s > PT_W'(32767)) return 16'h7fff;
    if (s < -PT_W'(32768)) return 16'h8000;
    return v[15:0];
  endfunction

  // edges of segment 0 (e0,e1) and segment 1 (e2,e3)
  function automatic logic [7:0] seg_edges(input logic [3:0] code);
    case (code)
      4'd1, 4'd14: return {EDGE_L, EDGE_B, EDGE_L, EDGE_L};
      4'd2, 4'd13: return {EDGE_L, EDGE_T, EDGE_L, EDGE_L};
      4'd3, 4'd12: return {EDGE_B, EDGE_T, EDGE_L, EDGE_L};
      4'd4, 4'd11: return {EDGE_T, EDGE_R, EDGE_L, EDGE_L};
      4'd5:        return {EDGE_L, EDGE_B, EDGE_T, EDGE_R};
      4'd6, 4'd9:  return {EDGE_L, EDGE_R, EDGE_L, EDGE_L};
      4'd7, 4'd8:  return {EDGE_B, EDGE_R, EDGE_L, EDGE_L};
      4'd10:       return {EDGE_L, EDGE_T, EDGE_B, EDGE_R};
      default:     return {EDGE_L, EDGE_L, EDGE_L, EDGE_L};
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/mscc_front.sv
`default_nettype none
module mscc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire mscc_pkg::in_item_t in_item,
  input  wire mscc_pkg::cfg_t    cfg,
  output logic                   drop,
  output mscc_pkg::front_t       front
);

  logic                 s1_v_r;
  mscc_pkg::in_item_t   s1_r;

  logic                 s2_v_r;
  logic [3:0][mscc_pkg::PROD_W-1:0] s2_prod_r;
  logic [3:0][mscc_pkg::DEN_W-1:0]  s2_den_r;
  logic [mscc_pkg::MUL_W-1:0] s2_mx_r;
  logic [mscc_pkg::MUL_W-1:0] s2_my_r;
  logic [3:0]           s2_code_r;

  mscc_pkg::front_t     s3_r;

  logic [3:0]  code;
  logic        keep;
  logic [3:0][15:0] num;
  logic [3:0][15:0] den;
  logic [3:0][14:0] stp;
  logic signed [15:0] p [4];
  logic signed [15:0] q [4];

  always_comb begin
    code = {s1_r.corner_br > cfg.threshold, s1_r.corner_tr > cfg.threshold,
            s1_r.corner_tl > cfg.threshold, s1_r.corner_bl > cfg.threshold};
    keep = (int'(s1_r.cell_col) < mscc_pkg::GRID_POINTS - 1) &&
           (int'(s1_r.cell_row) < mscc_pkg::GRID_POINTS - 1) &&
           (code != mscc_pkg::CODE_NONE_LO) && (code != mscc_pkg::CODE_NONE_HI);
    p[mscc_pkg::EDGE_L] = s1_r.corner_bl; q[mscc_pkg::EDGE_L] = s1_r.corner_tl;
    p[mscc_pkg::EDGE_B] = s1_r.corner_bl; q[mscc_pkg::EDGE_B] = s1_r.corner_br;
    p[mscc_pkg::EDGE_T] = s1_r.corner_tl; q[mscc_pkg::EDGE_T] = s1_r.corner_tr;
    p[mscc_pkg::EDGE_R] = s1_r.corner_br; q[mscc_pkg::EDGE_R] = s1_r.corner_tr;
    stp[mscc_pkg::EDGE_L] = cfg.step_y;
    stp[mscc_pkg::EDGE_B] = cfg.step_x;
    stp[mscc_pkg::EDGE_T] = cfg.step_x;
    stp[mscc_pkg::EDGE_R] = cfg.step_y;
    for (int e = 0; e < 4; e++) begin
      num[e] = mscc_pkg::abs_diff(cfg.threshold, p[e]);
      den[e] = mscc_pkg::abs_diff(q[e], p[e]);
      if (num[e] > den[e]) num[e] = den[e];
    end
  end

  assign drop = s1_v_r && !keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r && keep;
      s3_r.valid <= s2_v_r;
    end
    s1_r <= in_item;
    for (int e = 0; e < 4; e++) begin
      s2_prod_r[e] <= mscc_pkg::PROD_W'(stp[e]) * mscc_pkg::PROD_W'(num[e]);
      s2_den_r[e]  <= den[e];
      s3_r.prod[e] <= s2_prod_r[e];
      s3_r.den[e]  <= (s2_den_r[e] == '0) ? mscc_pkg::DEN_W'(1) : s2_den_r[e];
    end
    s2_mx_r   <= mscc_pkg::MUL_W'(s1_r.cell_col) * mscc_pkg::MUL_W'(cfg.step_x);
    s2_my_r   <= mscc_pkg::MUL_W'(s1_r.cell_row) * mscc_pkg::MUL_W'(cfg.step_y);
    s2_code_r <= code;
    s3_r.meta.code <= s2_code_r;
    s3_r.meta.ox <= {{(mscc_pkg::PT_W-16){cfg.origin_x[15]}}, cfg.origin_x} +
                    {{(mscc_pkg::PT_W-mscc_pkg::MUL_W){1'b0}}, s2_mx_r};
    s3_r.meta.oy <= {{(mscc_pkg::PT_W-16){cfg.origin_y[15]}}, cfg.origin_y} +
                    {{(mscc_pkg::PT_W-mscc_pkg::MUL_W){1'b0}}, s2_my_r};
  end

  assign front = s3_r;

endmodule
`default_nettype wire

FILE: design/mscc_div.sv
`default_nettype none
module mscc_div (
  input  wire logic                          clk,
  input  wire logic [mscc_pkg::PROD_W-1:0]   prod,
  input  wire logic [mscc_pkg::DEN_W-1:0]    den,
  output logic [mscc_pkg::DIV_BITS-1:0]      quot
);

  // restoring divider, one quotient bit per stage; prod < den << DIV_BITS
  logic [mscc_pkg::DEN_W-1:0]    rem_r [mscc_pkg::DIV_BITS];
  logic [mscc_pkg::DIV_BITS-1:0] lo_r  [mscc_pkg::DIV_BITS];
  logic [mscc_pkg::DIV_BITS-1:0] q_r   [mscc_pkg::DIV_BITS];
  logic [mscc_pkg::DEN_W-1:0]    d_r   [mscc_pkg::DIV_BITS];

  for (genvar k = 0; k < mscc_pkg::DIV_BITS; k++) begin : g_stage
    logic [mscc_pkg::DEN_W-1:0]    rem_i;
    logic [mscc_pkg::DEN_W-1:0]    d_i;
    logic [mscc_pkg::DIV_BITS-1:0] lo_i;
    logic [mscc_pkg::DIV_BITS-1:0] q_i;
    logic [mscc_pkg::DEN_W:0]      rem2;
    logic [mscc_pkg::DEN_W:0]      diff;
    logic                          ge;

    if (k == 0) begin : g_first
      assign rem_i = prod[mscc_pkg::PROD_W-1:mscc_pkg::DIV_BITS];
      assign lo_i  = prod[mscc_pkg::DIV_BITS-1:0];
      assign q_i   = '0;
      assign d_i   = den;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign q_i   = q_r[k-1];
      assign d_i   = d_r[k-1];
    end

    assign rem2 = {rem_i, lo_i[mscc_pkg::DIV_BITS-1]};
    assign ge   = rem2 >= {1'b0, d_i};
    assign diff = rem2 - {1'b0, d_i};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[mscc_pkg::DEN_W-1:0] : rem2[mscc_pkg::DEN_W-1:0];
      lo_r[k]  <= {lo_i[mscc_pkg::DIV_BITS-2:0], 1'b0};
      q_r[k]   <= {q_i[mscc_pkg::DIV_BITS-2:0], ge};
      d_r[k]   <= d_i;
    end
  end

  assign quot = q_r[mscc_pkg::DIV_BITS-1];

endmodule
`default_nettype wire

FILE: design/mscc_seg_fifo.sv
`default_nettype none
module mscc_seg_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mscc_pkg::ent_t    wdata,
  output logic                   pop,
  output logic                   out_strobe,
  output mscc_pkg::out_item_t    out_data
);

  mscc_pkg::ent_t mem [mscc_pkg::FIFO_DEPTH];
  logic [mscc_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mscc_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mscc_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;
  logic                         phase_r, phase_nxt;
  mscc_pkg::ent_t               head_r;
  logic                         emit;
  logic                         last;
  mscc_pkg::seg_t               seg;
  logic                         strobe_r;
  mscc_pkg::out_item_t          data_r;

  always_comb begin
    emit       = cnt_r != '0;
    last       = !head_r.two || phase_r;
    pop        = emit && last;
    seg        = phase_r ? head_r.seg1 : head_r.seg0;
    rd_ptr_nxt = rd_ptr_r + mscc_pkg::FIFO_AW'(pop);
    wr_ptr_nxt = wr_ptr_r + mscc_pkg::FIFO_AW'(push);
    cnt_nxt    = cnt_r + (mscc_pkg::FIFO_AW+1)'(push) - (mscc_pkg::FIFO_AW+1)'(pop);
    phase_nxt  = emit ? !last : phase_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
    // read-first array, bypass when the head is written this cycle
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wdata;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      strobe_r <= emit;
    end
    data_r.start_x      <= seg.x0;
    data_r.start_y      <= seg.y0;
    data_r.end_x        <= seg.x1;
    data_r.end_y        <= seg.y1;
    data_r.case_code    <= head_r.code;
    data_r.last_segment <= last;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (mscc_pkg::FIFO_AW+1)'(mscc_pkg::FIFO_DEPTH))
    else $error("fifo count overflow");
  a_phase_saddle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (emit && head_r.two))
    else $error("second segment without saddle entry");
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && head_r.two && !phase_r) |=> (phase_r && emit))
    else $error("saddle second segment missing");

endmodule
`default_nettype wire

FILE: design/marching_squares_cell_contour_unit.sv
`default_nettype none
// Path from start to the first segment strobe: 3 front stages, 15 divider
// stages, queue write and output register; a saddle cell's second segment
// follows in the next cycle. Throughput: one cell per cycle, one segment per
// cycle out; busy rises when 32 cells are in flight or queued.
// Synchronous active-low reset clears the pipeline, the queue and the
// registers to their defaults; results cannot be stalled by the receiver.
module marching_squares_cell_contour_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mscc_pkg::in_item_t  in_data,
  output logic                     out_strobe,
  output mscc_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  mscc_pkg::cfg_t   cfg_r;
  mscc_pkg::front_t front;
  logic             drop;
  logic             accept;
  logic             pop;
  logic             push;
  logic [mscc_pkg::FIFO_AW:0] tot_r, tot_nxt;

  logic [3:0][mscc_pkg::DIV_BITS-1:0] off;
  mscc_pkg::meta_t  meta_r [mscc_pkg::DIV_BITS];
  logic             val_r  [mscc_pkg::DIV_BITS];
  mscc_pkg::meta_t  m;
  logic [3:0][15:0] px;
  logic [3:0][15:0] py;
  logic [7:0]       edges;
  mscc_pkg::ent_t   ent;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = tot_r >= (mscc_pkg::FIFO_AW+1)'(mscc_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= 16'sd0;
      cfg_r.origin_x  <= -16'sd4096;
      cfg_r.origin_y  <= -16'sd4096;
      cfg_r.step_x    <= 15'd130;
      cfg_r.step_y    <= 15'd130;
    end else if (cfg_valid) begin
      case (cfg_index)
        mscc_pkg::CFG_THRESHOLD: cfg_r.threshold <= cfg_data;
        mscc_pkg::CFG_ORIGIN_X:  cfg_r.origin_x  <= cfg_data;
        mscc_pkg::CFG_ORIGIN_Y:  cfg_r.origin_y  <= cfg_data;
        mscc_pkg::CFG_STEP_X:    cfg_r.step_x    <= cfg_data[14:0];
        mscc_pkg::CFG_STEP_Y:    cfg_r.step_y    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  mscc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .drop     (drop),
    .front    (front)
  );

  for (genvar e = 0; e < 4; e++) begin : g_lane
    mscc_div u_div (
      .clk  (clk),
      .prod (front.prod[e]),
      .den  (front.den[e]),
      .quot (off[e])
    );
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mscc_pkg::DIV_BITS; k++) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= (k == 0) ? front.valid : val_r[(k == 0) ? 0 : k-1];
      end
      meta_r[k] <= (k == 0) ? front.meta : meta_r[(k == 0) ? 0 : k-1];
    end
  end

  always_comb begin
    m = meta_r[mscc_pkg::DIV_BITS-1];
    px[mscc_pkg::EDGE_L] = mscc_pkg::sat16(m.ox);
    py[mscc_pkg::EDGE_L] = mscc_pkg::sat16(m.oy +
      mscc_pkg::PT_W'(off[mscc_pkg::EDGE_L]));
    px[mscc_pkg::EDGE_B] = mscc_pkg::sat16(m.ox +
      mscc_pkg::PT_W'(off[mscc_pkg::EDGE_B]));
    py[mscc_pkg::EDGE_B] = mscc_pkg::sat16(m.oy);
    px[mscc_pkg::EDGE_T] = mscc_pkg::sat16(m.ox +
      mscc_pkg::PT_W'(off[mscc_pkg::EDGE_T]));
    py[mscc_pkg::EDGE_T] = mscc_pkg::sat16(m.oy + mscc_pkg::PT_W'(cfg_r.step_y));
    px[mscc_pkg::EDGE_R] = mscc_pkg::sat16(m.ox + mscc_pkg::PT_W'(cfg_r.step_x));
    py[mscc_pkg::EDGE_R] = mscc_pkg::sat16(m.oy +
      mscc_pkg::PT_W'(off[mscc_pkg::EDGE_R]));
    edges = mscc_pkg::seg_edges(m.code);
    ent.seg0.x0 = px[edges[7:6]];
    ent.seg0.y0 = py[edges[7:6]];
    ent.seg0.x1 = px[edges[5:4]];
    ent.seg0.y1 = py[edges[5:4]];
    ent.seg1.x0 = px[edges[3:2]];
    ent.seg1.y0 = py[edges[3:2]];
    ent.seg1.x1 = px[edges[1:0]];
    ent.seg1.y1 = py[edges[1:0]];
    ent.code = m.code;
    ent.two  = (m.code == mscc_pkg::CODE_SADDLE_A) || (m.code == mscc_pkg::CODE_SADDLE_B);
  end

  assign push = val_r[mscc_pkg::DIV_BITS-1];

  mscc_seg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wdata      (ent),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // cells in the pipeline plus cells in the queue
  assign tot_nxt = tot_r + (mscc_pkg::FIFO_AW+1)'(accept)
                 - (mscc_pkg::FIFO_AW+1)'(drop) - (mscc_pkg::FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else begin
      tot_r <= tot_nxt;
    end
  end

  a_tot_range: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= (mscc_pkg::FIFO_AW+1)'(mscc_pkg::FIFO_DEPTH))
    else $error("in-flight count overflow");
  a_push_counted: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> tot_r != '0)
    else $error("queue write without counted transaction");
  a_pop_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> tot_r != '0)
    else $error("queue read without counted transaction");
  a_no_drop_and_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (drop && pop) |-> tot_r >= (mscc_pkg::FIFO_AW+1)'(2))
    else $error("in-flight count underflow");

endmodule
`default_nettype wire
